// ----- rtl/ppsc_pkg.sv -----
// Shared types for the preemptive priority scheduler.
// No dependencies; imported by ppsc_cell and the top level.
package ppsc_pkg;

  localparam int unsigned REM_W = 16;

  // One loaded process record, id in the lowest bits.
  typedef struct packed {
    logic [7:0]       prio;
    logic [REM_W-1:0] burst;
    logic [15:0]      arr;
    logic [7:0]       id;
  } rec_t;

endpackage

// ----- rtl/preemptive_priority_scheduler_core.sv -----
// Preemptive priority scheduler: process records circulate in a ring of MAX_PROCS cells.
// Load: one record per cycle. Scheduling: one pass over all MAX_PROCS cells and
// then S_DECIDE per event (arrival or completion), at most 2n + 1 passes for n records.
// Results: one per record, one per cycle from record 0 at the head unless stalled.
// Reset (rst, synchronous) clears valid bits and counters at once; no clearing pass.
module preemptive_priority_scheduler_core
  import ppsc_pkg::*;
#(
  parameter int MAX_PROCS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [47:0]  s_tdata,   // process_id, arrival_time, burst_time, priority_req
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [119:0] m_tdata,   // process_id_res, completion_time, turnaround_time,
                                  // waiting_time, total_turnaround, total_waiting, pad
  output logic         m_tlast
);

  localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W = $clog2(MAX_PROCS + 1);
  localparam int NOW_W = 17 + $clog2(MAX_PROCS);
  localparam int SUM_W = 24;

  typedef enum logic [3:0] {
    S_LOAD   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DECIDE = 4'b0100,
    S_OUT    = 4'b1000
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] loaded_cnt, fin_cnt;
  logic [IDX_W-1:0] scan_cnt, out_idx, pick_idx, best_idx;
  logic [NOW_W-1:0] now;
  logic             pick_v, best_v, next_v;
  logic [REM_W-1:0] run, best_rem;
  logic [15:0]      best_arr, next_arr;
  logic [7:0]       best_prio;
  logic [SUM_W-1:0] tot_tat, tot_wt;

  // ring
  logic             q_v   [MAX_PROCS];
  logic             q_dn  [MAX_PROCS];
  rec_t             q_rec [MAX_PROCS];
  logic [REM_W-1:0] q_rem [MAX_PROCS];
  logic [NOW_W-1:0] q_fin [MAX_PROCS];
  logic [IDX_W-1:0] q_idx [MAX_PROCS];

  logic             ring_en, ring_clr;
  logic             t_v, t_dn;
  rec_t             t_rec;
  logic [REM_W-1:0] t_rem;
  logic [NOW_W-1:0] t_fin;
  logic [IDX_W-1:0] t_idx;

  for (genvar i = 0; i < MAX_PROCS; i++) begin : g_ring
    if (i == MAX_PROCS - 1) begin : g_tail
      ppsc_cell #(.IDX_W(IDX_W), .NOW_W(NOW_W)) u_cell (
        .clk(clk), .rst(rst), .en(ring_en), .clr(ring_clr),
        .d_v(t_v), .d_dn(t_dn), .d_rec(t_rec), .d_rem(t_rem), .d_fin(t_fin), .d_idx(t_idx),
        .q_v(q_v[i]), .q_dn(q_dn[i]), .q_rec(q_rec[i]), .q_rem(q_rem[i]),
        .q_fin(q_fin[i]), .q_idx(q_idx[i])
      );
    end else begin : g_mid
      ppsc_cell #(.IDX_W(IDX_W), .NOW_W(NOW_W)) u_cell (
        .clk(clk), .rst(rst), .en(ring_en), .clr(ring_clr),
        .d_v(q_v[i+1]), .d_dn(q_dn[i+1]), .d_rec(q_rec[i+1]), .d_rem(q_rem[i+1]),
        .d_fin(q_fin[i+1]), .d_idx(q_idx[i+1]),
        .q_v(q_v[i]), .q_dn(q_dn[i]), .q_rec(q_rec[i]), .q_rem(q_rem[i]),
        .q_fin(q_fin[i]), .q_idx(q_idx[i])
      );
    end
  end

  // input side
  logic             s_accept, room;
  logic [REM_W-1:0] burst_in, burst_eff;
  rec_t             new_rec;

  assign s_tready  = (state == S_LOAD);
  assign s_accept  = s_tvalid && s_tready;
  assign room      = (loaded_cnt < CNT_W'(MAX_PROCS));
  assign burst_in  = s_tdata[39:24];
  assign burst_eff = (burst_in == '0) ? REM_W'(1) : burst_in;
  assign new_rec   = '{prio: s_tdata[47:40], burst: burst_eff, arr: s_tdata[23:8],
                       id: s_tdata[7:0]};

  // head: apply last decision, then evaluate
  logic             upd, fin_hit, done_u, elig, fut, better, sooner;
  logic [REM_W-1:0] rem_u;
  logic [NOW_W-1:0] fin_u, arr_h;

  assign upd     = q_v[0] && pick_v && (q_idx[0] == pick_idx);
  assign rem_u   = upd ? (q_rem[0] - run) : q_rem[0];
  assign fin_hit = upd && (rem_u == '0);
  assign done_u  = q_dn[0] || fin_hit;
  assign fin_u   = fin_hit ? now : q_fin[0];
  assign arr_h   = NOW_W'(q_rec[0].arr);
  assign elig    = q_v[0] && !done_u && (arr_h <= now);
  assign fut     = q_v[0] && !done_u && (arr_h > now);
  assign better  = !best_v || (q_rec[0].prio > best_prio) ||
                   ((q_rec[0].prio == best_prio) && ((q_rec[0].arr < best_arr) ||
                    ((q_rec[0].arr == best_arr) && (q_idx[0] < best_idx))));
  assign sooner  = !next_v || (q_rec[0].arr < next_arr);

  // decision after a full pass
  logic [NOW_W-1:0] gap;
  logic [REM_W-1:0] run_sel;

  assign gap     = NOW_W'(next_arr) - now;
  assign run_sel = (next_v && (gap < NOW_W'(best_rem))) ? gap[REM_W-1:0] : best_rem;

  // output side
  logic             can_emit, emit_match, emit, out_last;
  logic [NOW_W-1:0] tat, wt;
  logic [SUM_W-1:0] tot_tat_next, tot_wt_next;

  assign can_emit     = !m_tvalid || m_tready;
  assign emit_match   = q_v[0] && (q_idx[0] == out_idx);
  assign emit         = (state == S_OUT) && emit_match && can_emit;
  assign out_last     = (out_idx == IDX_W'(loaded_cnt - CNT_W'(1)));
  assign tat          = q_fin[0] - arr_h;
  assign wt           = tat - NOW_W'(q_rec[0].burst);
  assign tot_tat_next = tot_tat + SUM_W'(tat);
  assign tot_wt_next  = tot_wt + SUM_W'(wt);

  always_comb begin
    t_v   = q_v[0];
    t_dn  = q_dn[0];
    t_rec = q_rec[0];
    t_rem = q_rem[0];
    t_fin = q_fin[0];
    t_idx = q_idx[0];
    ring_en = 1'b0;
    case (state)
      S_LOAD: begin
        t_v     = 1'b1;
        t_dn    = 1'b0;
        t_rec   = new_rec;
        t_rem   = burst_eff;
        t_idx   = IDX_W'(loaded_cnt);
        ring_en = s_accept && room;
      end
      S_SCAN: begin
        t_dn    = done_u;
        t_rem   = rem_u;
        t_fin   = fin_u;
        ring_en = 1'b1;
      end
      S_OUT: begin
        ring_en = !(emit_match && !can_emit);
      end
      default: begin
        ring_en = 1'b0;
      end
    endcase
  end

  assign ring_clr = emit && out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      loaded_cnt <= '0;
      fin_cnt    <= '0;
      now        <= '0;
      pick_v     <= 1'b0;
      best_v     <= 1'b0;
      next_v     <= 1'b0;
      scan_cnt   <= '0;
      out_idx    <= '0;
    end else begin
      case (state)
        S_LOAD: begin
          if (s_accept) begin
            if (room) loaded_cnt <= loaded_cnt + CNT_W'(1);
            if (s_tlast) begin
              state    <= S_SCAN;
              scan_cnt <= '0;
            end
          end
        end
        S_SCAN: begin
          scan_cnt <= scan_cnt + IDX_W'(1);
          if (fin_hit) fin_cnt <= fin_cnt + CNT_W'(1);
          if (elig && better) begin
            best_v    <= 1'b1;
            best_idx  <= q_idx[0];
            best_prio <= q_rec[0].prio;
            best_arr  <= q_rec[0].arr;
            best_rem  <= rem_u;
          end
          if (fut && sooner) begin
            next_v   <= 1'b1;
            next_arr <= q_rec[0].arr;
          end
          if (scan_cnt == IDX_W'(MAX_PROCS - 1)) state <= S_DECIDE;
        end
        S_DECIDE: begin
          best_v   <= 1'b0;
          next_v   <= 1'b0;
          scan_cnt <= '0;
          if (fin_cnt == loaded_cnt) begin
            state   <= S_OUT;
            out_idx <= '0;
            pick_v  <= 1'b0;
          end else if (!best_v) begin
            now    <= NOW_W'(next_arr);
            pick_v <= 1'b0;
            state  <= S_SCAN;
          end else begin
            now      <= now + NOW_W'(run_sel);
            run      <= run_sel;
            pick_idx <= best_idx;
            pick_v   <= 1'b1;
            state    <= S_SCAN;
          end
        end
        S_OUT: begin
          if (emit) begin
            if (out_last) begin
              state      <= S_LOAD;
              loaded_cnt <= '0;
              fin_cnt    <= '0;
              now        <= '0;
            end else begin
              out_idx <= out_idx + IDX_W'(1);
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      tot_tat  <= '0;
      tot_wt   <= '0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
      tot_tat  <= out_last ? '0 : tot_tat_next;
      tot_wt   <= out_last ? '0 : tot_wt_next;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= {3'b000, tot_wt_next, tot_tat_next, 20'(wt), 20'(tat),
                  21'(q_fin[0]), q_rec[0].id};
      m_tlast <= out_last;
    end
  end

  a_fin_le_loaded: assert property (@(posedge clk) disable iff (rst)
    fin_cnt <= loaded_cnt)
    else $error("finished count above loaded count");

  a_decide_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_DECIDE) |=> (state == S_SCAN || state == S_OUT))
    else $error("bad exit from decision cycle");

  a_run_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && pick_v) |-> (run != '0))
    else $error("zero-length run scheduled");

  a_batch_clear: assert property (@(posedge clk) disable iff (rst)
    (emit && out_last) |=> (loaded_cnt == '0 && fin_cnt == '0 && now == '0 &&
                             m_tvalid && m_tlast))
    else $error("batch state not cleared after final transfer");

endmodule

// ----- rtl/ppsc_cell.sv -----
// One stage of the process ring: a record plus its run state.
// Depends on ppsc_pkg.
module ppsc_cell
  import ppsc_pkg::*;
#(
  parameter int IDX_W = 4,
  parameter int NOW_W = 21
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             clr,
  input  logic             d_v,
  input  logic             d_dn,
  input  rec_t             d_rec,
  input  logic [REM_W-1:0] d_rem,
  input  logic [NOW_W-1:0] d_fin,
  input  logic [IDX_W-1:0] d_idx,
  output logic             q_v,
  output logic             q_dn,
  output rec_t             q_rec,
  output logic [REM_W-1:0] q_rem,
  output logic [NOW_W-1:0] q_fin,
  output logic [IDX_W-1:0] q_idx
);

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      q_v  <= 1'b0;
      q_dn <= 1'b0;
    end else if (en) begin
      q_v  <= d_v;
      q_dn <= d_dn;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_rec <= d_rec;
      q_rem <= d_rem;
      q_fin <= d_fin;
      q_idx <= d_idx;
    end
  end

endmodule
